// File: rtl/core/selective_repeat_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the selective-repeat receiver RTL
// Both macros expect clk and arst_n in the scope of their use.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types and fixed constants of the selective-repeat receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

	// Sequence numbers and slot indexes are 3 bits; the slot array has 8 entries
	localparam int SEQ_BITS = 3;
	localparam int SLOTS    = 8;
	localparam int WORD_BITS = 32;

	// Result kinds
	localparam logic KIND_ACK     = 1'b0;
	localparam logic KIND_DELIVER = 1'b1;

	typedef struct packed {
		logic                 checksum_ok;
		logic [SEQ_BITS-1:0]  sequence_number;
		logic [WORD_BITS-1:0] payload_word;
	} srr_in_t;

	typedef struct packed {
		logic                 result_kind;
		logic [SEQ_BITS-1:0]  ack_number;
		logic [WORD_BITS-1:0] delivered_payload;
		logic                 last_of_run;
	} srr_out_t;

	// Payload memory access request
	typedef struct packed {
		logic                wr_en;
		logic [SEQ_BITS-1:0] wr_addr;
		logic                rd_en;
		logic [SEQ_BITS-1:0] rd_addr;
	} srr_mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/selective_repeat_receiver_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Selective-repeat ARQ receiver: acknowledges and reorders packets.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one packet per transfer, with
//   checksum flag, sequence number and payload word.
//   out channel (out_valid/out_ready/out_data): results of a packet, the
//   acknowledgement first, then in-order deliveries; last_of_run marks the
//   final result of that packet. Corrupt or out-of-range packets give none.
//   The acknowledgement is registered and appears in the cycle after the input transfer.
//   Each buffered word that a base packet releases needs a read of the slot
//   memory (registered read data) and then an emit; a packet that gives no
//   delivery needs neither.
//   in_ready is low while a delivery run is in progress.
//   A stalled out channel holds the result register and stops the walk;
//   new packets are taken only when the output register can be refilled.
//   Reset clears the window base, all received marks and the output valid;
//   the slot memory needs no clearing, entries are read only once marked.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver_top #(
	parameter int WINDOW       = 4,
	parameter int SEQ_SPACE    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  srr_pkg::srr_in_t   in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output srr_pkg::srr_out_t  out_data
);

	srr_pkg::srr_mem_req_t   mem_req;
	logic [PAYLOAD_BITS-1:0] mem_wdata;
	logic [PAYLOAD_BITS-1:0] mem_rdata;

	// Control and sequencing
	srr_ctrl #(
		.WINDOW       (WINDOW),
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem_req   (mem_req),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// Slot payload memory
	srr_mem #(
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// File: rtl/core/srr_mem.sv
// ----------------------------------------------------------------------------
// srr_mem
// Slot payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_mem #(
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                       clk,
	input  srr_pkg::srr_mem_req_t     req,
	input  wire  [PAYLOAD_BITS-1:0]   wdata,
	output logic [PAYLOAD_BITS-1:0]   rdata
);

	logic [PAYLOAD_BITS-1:0] mem_q [srr_pkg::SLOTS];

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem_q[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl
// Window tracking, received marks, delivery walk and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_receiver_top_macros.svh"

module srr_ctrl #(
	parameter int WINDOW       = 4,
	parameter int SEQ_SPACE    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  srr_pkg::srr_in_t           in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output srr_pkg::srr_out_t          out_data,
	output srr_pkg::srr_mem_req_t      mem_req,
	output logic [PAYLOAD_BITS-1:0]    mem_wdata,
	input  wire  [PAYLOAD_BITS-1:0]    mem_rdata
);

	localparam int SB      = srr_pkg::SEQ_BITS;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int PREV_LO = (SEQ_SPACE > WINDOW) ? (SEQ_SPACE - WINDOW) : SEQ_SPACE;
	localparam logic [SB:0]      SS_W   = (SB + 1)'(SEQ_SPACE);
	localparam logic [SB:0]      WIN_W  = (SB + 1)'(WINDOW);
	localparam logic [SB:0]      PREV_W = (SB + 1)'(PREV_LO);
	localparam logic [CNT_W-1:0] WIN_C  = CNT_W'(WINDOW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]               state_q;
	logic [SB-1:0]            base_q;
	logic [SB-1:0]            pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [srr_pkg::SLOTS-1:0] recv_q;
	logic                     out_valid_q;
	srr_pkg::srr_out_t        out_q;

	logic                     out_free;
	logic                     accept;
	logic [SB-1:0]            seq;
	logic                     seq_ok;
	logic [SB:0]              dsum;
	logic [SB:0]              seq_dist;
	logic                     in_win;
	logic                     in_prev;
	logic                     is_base;
	logic [SB:0]              pos_inc;
	logic [SB-1:0]            pos_nxt;
	logic [CNT_W-1:0]         count_nxt;
	logic                     more;
	logic                     out_load;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Window classification of the incoming packet
	always_comb begin
		seq      = in_data.sequence_number;
		seq_ok   = in_data.checksum_ok && ({1'b0, seq} < SS_W);
		dsum     = {1'b0, seq} + SS_W - {1'b0, base_q};
		seq_dist = (dsum >= SS_W) ? (dsum - SS_W) : dsum;
		in_win   = seq_dist < WIN_W;
		in_prev  = seq_dist >= PREV_W;
		is_base  = (seq == base_q);
	end

	// Walk bookkeeping
	always_comb begin
		pos_inc   = {1'b0, pos_q} + 1'b1;
		pos_nxt   = (pos_inc == SS_W) ? '0 : pos_inc[SB-1:0];
		count_nxt = count_q + 1'b1;
		more      = recv_q[pos_nxt] && (count_nxt < WIN_C);
	end

	// Output register is refilled by an acknowledgement or a delivery
	assign out_load = (accept && seq_ok && (in_win || in_prev)) ||
		((state_q == ST_EMIT) && out_free);

	// Payload memory requests
	always_comb begin
		mem_req.wr_en   = accept && seq_ok && in_win && !recv_q[seq];
		mem_req.wr_addr = seq;
		mem_req.rd_en   = (state_q == ST_READ);
		mem_req.rd_addr = pos_q;
		mem_wdata       = PAYLOAD_BITS'(in_data.payload_word);
	end

	// Sequencer, marks and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			recv_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && seq_ok && in_win) begin
						if (!recv_q[seq]) begin
							recv_q[seq] <= 1'b1;
						end
						if (is_base) begin
							state_q <= ST_READ;
							pos_q   <= base_q;
							count_q <= '0;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						recv_q[pos_q]  <= 1'b0;
						pos_q          <= pos_nxt;
						count_q        <= count_nxt;
						if (more) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
							base_q  <= pos_nxt;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (accept && seq_ok && (in_win || in_prev)) begin
			out_q.result_kind       <= srr_pkg::KIND_ACK;
			out_q.ack_number        <= seq;
			out_q.delivered_payload <= '0;
			out_q.last_of_run       <= !(in_win && is_base);
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_q.result_kind       <= srr_pkg::KIND_DELIVER;
			out_q.ack_number        <= '0;
			out_q.delivered_payload <= srr_pkg::WORD_BITS'(mem_rdata);
			out_q.last_of_run       <= !more;
		end
	end

	// Checks
	`SRR_ASSERT_NOW(a_base_range, 1'b1, {1'b0, base_q} < SS_W, "window base outside sequence space")
	`SRR_ASSERT_NOW(a_emit_marked, state_q == ST_EMIT, recv_q[pos_q], "delivering an unmarked slot")
	`SRR_ASSERT_NOW(a_walk_bound, state_q != ST_IDLE, count_q < WIN_C, "walk ran past the window")
	`SRR_ASSERT_NEXT(a_walk_start, accept && seq_ok && in_win && is_base,
		(state_q == ST_READ) && recv_q[pos_q], "base packet did not start a walk")

endmodule

`default_nettype wire
